// ===== rtl/assert_macros.svh =====
// Assertion helpers; they compile to nothing when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VIA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define VIA_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`else
`define VIA_ASSERT(lbl, expr, msg)
`define VIA_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

// ===== rtl/via_pkg.sv =====
package via_pkg;

  typedef enum logic [3:0] {
    ACT_TICK  = 4'd0,
    ACT_READ  = 4'd1,
    ACT_WRITE = 4'd2,
    ACT_PA    = 4'd3,
    ACT_PB    = 4'd4,
    ACT_CA1   = 4'd5,
    ACT_CA2   = 4'd6,
    ACT_CB1   = 4'd7,
    ACT_CB2   = 4'd8
  } via_act_t;

  typedef enum logic [3:0] {
    REG_ORB   = 4'd0,
    REG_ORA   = 4'd1,
    REG_DDRB  = 4'd2,
    REG_DDRA  = 4'd3,
    REG_T1CL  = 4'd4,
    REG_T1CH  = 4'd5,
    REG_T1LL  = 4'd6,
    REG_T1LH  = 4'd7,
    REG_T2CL  = 4'd8,
    REG_T2CH  = 4'd9,
    REG_SR    = 4'd10,
    REG_ACR   = 4'd11,
    REG_PCR   = 4'd12,
    REG_IFR   = 4'd13,
    REG_IER   = 4'd14,
    REG_IORA2 = 4'd15
  } via_reg_t;

  localparam logic [7:0] FLAG_CA2 = 8'h01;
  localparam logic [7:0] FLAG_CA1 = 8'h02;
  localparam logic [7:0] FLAG_SR  = 8'h04;
  localparam logic [7:0] FLAG_CB2 = 8'h08;
  localparam logic [7:0] FLAG_CB1 = 8'h10;
  localparam logic [7:0] FLAG_T2  = 8'h20;
  localparam logic [7:0] FLAG_T1  = 8'h40;

  typedef struct packed {
    logic [7:0]  out_a;
    logic [7:0]  out_b;
    logic [7:0]  dir_a;
    logic [7:0]  dir_b;
    logic [7:0]  in_a;
    logic [7:0]  in_b;
    logic [7:0]  in_a_l;
    logic [7:0]  in_b_l;
    logic [15:0] t1_cnt;
    logic [15:0] t1_lat;
    logic        t1_run;
    logic        t1_rld;
    logic [15:0] t2_cnt;
    logic [15:0] t2_lat;
    logic        t2_run;
    logic        t2_skip;
    logic [7:0]  sr_data;
    logic [3:0]  sr_cnt;
    logic [7:0]  sr_div;
    logic        sr_act;
    logic [7:0]  acr;
    logic [7:0]  pcr;
    logic [7:0]  ifr;
    logic [6:0]  ier;
    logic        ca1;
    logic        ca2;
    logic        ca2_pend;
    logic        cb1;
    logic        cb2;
    logic        cb2_pend;
  } via_state_t;

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] reg_offset;
    logic [7:0] data_in;
    logic [2:0] pin_bit;
  } via_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       irq_request;
    logic       irq_release;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic       ca2_level;
    logic       cb1_level;
    logic       cb2_level;
    logic       orb_written;
    logic       porta_update;
  } via_res_t;

endpackage

// ===== rtl/versatile_interface_adapter.sv =====
// channel | signals                                        | role
// in      | in_valid/in_ready, action, reg_offset, data, pin | request into the adapter
// out     | out_valid/out_ready, read_data .. porta_update   | one result per request
// One request per clock while out_ready holds; path: input register, result register.
// The state update runs in one pass of via_core when the request leaves the input register.
// Synchronous active-low reset clears all state and both valid flags.
// A stalled result holds; the input register still takes a request while it frees.
`include "assert_macros.svh"
module versatile_interface_adapter import via_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_action,
  input  logic [3:0] in_reg_offset,
  input  logic [7:0] in_data_in,
  input  logic [2:0] in_pin_bit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq_line,
  output logic       out_irq_request,
  output logic       out_irq_release,
  output logic [7:0] out_port_a_out,
  output logic [7:0] out_port_b_out,
  output logic       out_ca2_level,
  output logic       out_cb1_level,
  output logic       out_cb2_level,
  output logic       out_orb_written,
  output logic       out_porta_update
);

  via_req_t   rq_r;
  logic       rq_valid_r;
  via_state_t st_r, st_nxt;
  via_res_t   res_r, res_nxt;
  logic       res_valid_r;
  logic       advance;

  assign advance  = rq_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !rq_valid_r || advance;

  via_core u_core (
    .st     (st_r),
    .rq     (rq_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) rq_valid_r <= in_valid;
      if (advance) begin
        st_r        <= st_nxt;
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rq_r.action     <= in_action;
      rq_r.reg_offset <= in_reg_offset;
      rq_r.data_in    <= in_data_in;
      rq_r.pin_bit    <= in_pin_bit;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid        = res_valid_r;
  assign out_read_data    = res_r.read_data;
  assign out_irq_line     = res_r.irq_line;
  assign out_irq_request  = res_r.irq_request;
  assign out_irq_release  = res_r.irq_release;
  assign out_port_a_out   = res_r.port_a_out;
  assign out_port_b_out   = res_r.port_b_out;
  assign out_ca2_level    = res_r.ca2_level;
  assign out_cb1_level    = res_r.cb1_level;
  assign out_cb2_level    = res_r.cb2_level;
  assign out_orb_written  = res_r.orb_written;
  assign out_porta_update = res_r.porta_update;

  `VIA_ASSERT(a_irq_sum, st_r.ifr[7] == (|(st_r.ifr[6:0] & st_r.ier)), "IFR bit 7 out of step")
  `VIA_ASSERT(a_req_rel, !(res_valid_r && res_r.irq_request && res_r.irq_release), "request and release together")
  `VIA_ASSERT(a_line_state, !res_valid_r || res_r.irq_line == st_r.ifr[7], "irq line disagrees with state")
  `VIA_ASSERT_NEXT(a_advance, advance, res_valid_r, "result lost after advance")

endmodule

// ===== rtl/via_core.sv =====
module via_core import via_pkg::*; (
  input  via_state_t st,
  input  via_req_t   rq,
  output via_state_t st_nxt,
  output via_res_t   res
);

  function automatic via_state_t raise(input via_state_t s, input logic [7:0] b);
    via_state_t t;
    t = s;
    t.ifr = t.ifr | b;
    if (t.acr[0] && b[1]) t.in_a_l = t.in_a;
    if (t.acr[1] && b[4]) t.in_b_l = t.in_b;
    if (|(t.ifr[6:0] & t.ier)) t.ifr[7] = 1'b1;
    return t;
  endfunction

  function automatic via_state_t drop(input via_state_t s, input logic [7:0] b);
    via_state_t t;
    t = s;
    t.ifr = t.ifr & ~b;
    if (!(|(t.ifr[6:0] & t.ier))) t.ifr[7] = 1'b0;
    return t;
  endfunction

  via_state_t s;
  logic       req, rel, orb, pa, lvl, go;
  logic [7:0] rd, m;
  logic [2:0] md;

  always_comb begin
    s   = st;
    req = 1'b0;
    rel = 1'b0;
    orb = 1'b0;
    pa  = 1'b0;
    go  = 1'b0;
    rd  = 8'h00;
    lvl = rq.data_in[0];
    m   = 8'h01 << rq.pin_bit;
    md  = s.acr[4:2];
    case (rq.action)
      ACT_TICK: begin
        if (s.ca2_pend) begin
          s.ca2 = 1'b1;
          s.ca2_pend = 1'b0;
        end
        if (s.cb2_pend) begin
          s.cb2 = 1'b1;
          s.cb2_pend = 1'b0;
        end
        if (s.t1_rld) begin
          s.t1_rld = 1'b0;
          s.t1_cnt = s.t1_lat;
        end else begin
          if (s.acr[6]) begin
            if (s.t1_cnt == 16'h0000) begin
              s = raise(s, FLAG_T1);
              req = req | (|(FLAG_T1[6:0] & s.ier));
              if (s.acr[7]) s.out_b[7] = ~s.out_b[7];
              s.t1_rld = 1'b1;
            end
          end else if (s.t1_run && s.t1_cnt == 16'h0000) begin
            s = raise(s, FLAG_T1);
            req = req | (|(FLAG_T1[6:0] & s.ier));
            if (s.acr[7]) s.out_b[7] = 1'b1;
            s.t1_run = 1'b0;
          end
          s.t1_cnt = s.t1_cnt - 16'd1;
        end
        if (!s.acr[5]) begin
          if (s.t2_skip) begin
            s.t2_skip = 1'b0;
          end else begin
            if (s.t2_run && s.t2_cnt == 16'h0000) begin
              s = raise(s, FLAG_T2);
              req = req | (|(FLAG_T2[6:0] & s.ier));
              s.t2_run = 1'b0;
            end
            s.t2_cnt = s.t2_cnt - 16'd1;
          end
        end
        if (md == 3'd3 || md == 3'd7) begin
          if (s.ifr[2]) s = drop(s, FLAG_SR);
          s.sr_act = 1'b0;
          s.sr_cnt = 4'd0;
        end else if (md != 3'd0 && s.sr_act) begin
          go = 1'b1;
          if (md == 3'd1 || md == 3'd4 || md == 3'd5) begin
            if (s.sr_div == 8'h00) begin
              s.sr_div = s.t2_lat[7:0];
              go = 1'b0;
            end else begin
              s.sr_div = s.sr_div - 8'd1;
              go = (s.sr_div == 8'h00);
            end
          end
          if (go) begin
            s.cb1 = ~s.cb1;
            if (md == 3'd1 || md == 3'd2) begin
              if (s.cb1) begin
                s.sr_data = {s.sr_data[6:0], s.cb2};
                s.sr_cnt = s.sr_cnt + 4'd1;
                if (s.sr_cnt == 4'd8) begin
                  s = raise(s, FLAG_SR);
                  req = req | (|(FLAG_SR[6:0] & s.ier));
                  s.sr_div = 8'h00;
                  s.sr_act = 1'b0;
                end
              end
            end else if (!s.cb1) begin
              s.cb2 = s.sr_data[7];
              s.sr_data = {s.sr_data[6:0], s.cb2};
              if (md == 3'd4) begin
                s.sr_cnt = {1'b0, s.sr_cnt[2:0] + 3'd1};
              end else begin
                s.sr_cnt = s.sr_cnt + 4'd1;
                if (s.sr_cnt == 4'd8) begin
                  s = raise(s, FLAG_SR);
                  req = req | (|(FLAG_SR[6:0] & s.ier));
                  s.sr_div = 8'h00;
                  s.sr_act = 1'b0;
                end
              end
            end
          end
        end
      end
      ACT_READ: begin
        unique case (rq.reg_offset)
          REG_ORB: begin
            s = drop(s, FLAG_CB1);
            case (s.pcr[7:5])
              3'd0, 3'd2: s = drop(s, FLAG_CB2);
              3'd4: s.cb2 = 1'b0;
              3'd5: begin
                s.cb2 = 1'b0;
                s.cb2_pend = 1'b1;
              end
              default: ;
            endcase
            rd = (s.out_b & s.dir_b) | ((s.acr[1] ? s.in_b_l : s.in_b) & ~s.dir_b);
          end
          REG_ORA: begin
            s = drop(s, FLAG_CA1);
            case (s.pcr[3:1])
              3'd0, 3'd2: s = drop(s, FLAG_CA2);
              3'd4: s.ca2 = 1'b0;
              3'd5: begin
                s.ca2 = 1'b0;
                s.ca2_pend = 1'b1;
              end
              default: ;
            endcase
            rd = (s.out_a & s.dir_a) | ((s.acr[0] ? s.in_a_l : s.in_a) & ~s.dir_a);
          end
          REG_DDRB: rd = s.dir_b;
          REG_DDRA: rd = s.dir_a;
          REG_T1CL: begin
            s = drop(s, FLAG_T1);
            rd = s.t1_cnt[7:0];
          end
          REG_T1CH: rd = s.t1_cnt[15:8];
          REG_T1LL: rd = s.t1_lat[7:0];
          REG_T1LH: rd = s.t1_lat[15:8];
          REG_T2CL: begin
            s = drop(s, FLAG_T2);
            rd = s.t2_cnt[7:0];
          end
          REG_T2CH: rd = s.t2_cnt[15:8];
          REG_SR: begin
            s.sr_div = 8'h00;
            s.sr_cnt = 4'd0;
            s.sr_act = 1'b1;
            s = drop(s, FLAG_SR);
            rd = s.sr_data;
          end
          REG_ACR: rd = s.acr;
          REG_PCR: rd = s.pcr;
          REG_IFR: rd = s.ifr;
          REG_IER: rd = {1'b1, s.ier};
          default: rd = (s.out_a & s.dir_a) | (s.in_a & ~s.dir_a);
        endcase
      end
      ACT_WRITE: begin
        unique case (rq.reg_offset)
          REG_ORB: begin
            s.out_b = rq.data_in;
            s = drop(s, FLAG_CB1);
            case (s.pcr[7:5])
              3'd0, 3'd2: s = drop(s, FLAG_CB2);
              3'd4: s.cb2 = 1'b0;
              3'd5: begin
                s.cb2 = 1'b0;
                s.cb2_pend = 1'b1;
              end
              default: ;
            endcase
            orb = 1'b1;
          end
          REG_ORA: begin
            s.out_a = rq.data_in;
            s = drop(s, FLAG_CA1);
            case (s.pcr[3:1])
              3'd0, 3'd2: s = drop(s, FLAG_CA2);
              3'd4: s.ca2 = 1'b0;
              3'd5: begin
                s.ca2 = 1'b0;
                s.ca2_pend = 1'b1;
              end
              default: ;
            endcase
            pa = 1'b1;
          end
          REG_DDRB: s.dir_b = rq.data_in;
          REG_DDRA: s.dir_a = rq.data_in;
          REG_T1CL, REG_T1LL: s.t1_lat[7:0] = rq.data_in;
          REG_T1CH: begin
            s.t1_lat[15:8] = rq.data_in;
            s.t1_cnt = s.t1_lat;
            s.t1_rld = 1'b1;
            s.t1_run = 1'b1;
            s = drop(s, FLAG_T1);
            if (s.acr[7:6] == 2'b10) s.out_b[7] = 1'b0;
          end
          REG_T1LH: begin
            s.t1_lat[15:8] = rq.data_in;
            s = drop(s, FLAG_T1);
          end
          REG_T2CL: s.t2_lat[7:0] = rq.data_in;
          REG_T2CH: begin
            s.t2_lat[15:8] = rq.data_in;
            s.t2_cnt = s.t2_lat;
            s.t2_run = 1'b1;
            s.t2_skip = 1'b1;
            s = drop(s, FLAG_T2);
          end
          REG_SR: begin
            s.sr_data = rq.data_in;
            s.sr_div = 8'h00;
            s.sr_cnt = 4'd0;
            s.sr_act = 1'b1;
            s = drop(s, FLAG_SR);
          end
          REG_ACR: begin
            s.acr = rq.data_in;
            if (!rq.data_in[6]) s.t1_rld = 1'b0;
          end
          REG_PCR: begin
            s.pcr = rq.data_in;
            if (rq.data_in[3:1] == 3'd6) begin
              s.ca2 = 1'b0;
              s.ca2_pend = 1'b0;
            end else if (rq.data_in[3:1] == 3'd7) begin
              s.ca2 = 1'b1;
            end
            if (rq.data_in[7:5] == 3'd6) begin
              s.cb2 = 1'b0;
              s.cb2_pend = 1'b0;
            end else if (rq.data_in[7:5] == 3'd7) begin
              s.cb2 = 1'b1;
            end
            pa = 1'b1;
          end
          REG_IFR: begin
            s.ifr = s.ifr & {1'b0, ~rq.data_in[6:0]};
            if (|(s.ifr[6:0] & s.ier)) s.ifr[7] = 1'b1;
            else rel = 1'b1;
          end
          REG_IER: begin
            if (rq.data_in[7]) s.ier = s.ier | rq.data_in[6:0];
            else s.ier = s.ier & ~rq.data_in[6:0];
            if (|(s.ifr[6:0] & s.ier)) begin
              if (!s.ifr[7]) begin
                req = 1'b1;
                s.ifr[7] = 1'b1;
              end
            end else begin
              rel = 1'b1;
              s.ifr[7] = 1'b0;
            end
          end
          default: begin
            s.out_a = rq.data_in;
            pa = 1'b1;
          end
        endcase
      end
      ACT_PA: s.in_a = (s.in_a & ~m) | (lvl ? m : 8'h00);
      ACT_PB: begin
        go = s.in_b[6];
        s.in_b = (s.in_b & ~m) | (lvl ? m : 8'h00);
        if (s.acr[5] && rq.pin_bit == 3'd6 && go && !lvl) begin
          s.t2_cnt = s.t2_cnt - 16'd1;
          if (s.t2_run && s.t2_cnt == 16'h0000) begin
            s = raise(s, FLAG_T2);
            req = req | (|(FLAG_T2[6:0] & s.ier));
            s.t2_run = 1'b0;
          end
        end
      end
      ACT_CA1: begin
        if (s.ca1 != lvl) begin
          s.ca1 = lvl;
          if (lvl == s.pcr[0]) begin
            s = raise(s, FLAG_CA1);
            req = req | (|(FLAG_CA1[6:0] & s.ier));
          end
          if (lvl && !s.ca2 && s.pcr[3:1] == 3'd4) s.ca2 = 1'b1;
        end
      end
      ACT_CA2: begin
        if (s.ca2 != lvl) begin
          s.ca2 = lvl;
          if ((lvl && s.pcr[3:2] == 2'd1) || (!lvl && s.pcr[3:2] == 2'd0)) begin
            s = raise(s, FLAG_CA2);
            req = req | (|(FLAG_CA2[6:0] & s.ier));
          end
        end
      end
      ACT_CB1: begin
        if (s.cb1 != lvl) begin
          s.cb1 = lvl;
          if (lvl == s.pcr[4]) begin
            s = raise(s, FLAG_CB1);
            req = req | (|(FLAG_CB1[6:0] & s.ier));
          end
          if (lvl && !s.cb2 && s.pcr[7:5] == 3'd4) s.cb2 = 1'b1;
        end
      end
      ACT_CB2: begin
        if (s.cb2 != lvl) begin
          s.cb2 = lvl;
          if ((lvl && s.pcr[7:6] == 2'd1) || (!lvl && s.pcr[7:6] == 2'd0)) begin
            s = raise(s, FLAG_CB2);
            req = req | (|(FLAG_CB2[6:0] & s.ier));
          end
        end
      end
      default: ;
    endcase
    st_nxt = s;
    res.read_data    = rd;
    res.irq_line     = s.ifr[7];
    res.irq_request  = req;
    res.irq_release  = rel;
    res.port_a_out   = s.out_a;
    res.port_b_out   = s.out_b;
    res.ca2_level    = s.ca2;
    res.cb1_level    = s.cb1;
    res.cb2_level    = s.cb2;
    res.orb_written  = orb;
    res.porta_update = pa;
  end

endmodule
